@@ sv/a85_pkg.sv @@
package a85_pkg;

    // Character codes.
    localparam logic [6:0] ZERO_CHAR  = 7'd122;
    localparam logic [6:0] DIGIT_BASE = 7'd33;

    // Base-85 conversion constants.
    localparam int unsigned DIGITS     = 5;
    localparam logic [6:0]  RADIX      = 7'd85;
    localparam logic [2:0]  LAST_DIGIT = 3'(DIGITS - 1);
    localparam logic [1:0]  LAST_BYTE  = 2'd3;

    // The group value is scaled by RECIP = ceil(2^FRAC_BITS / 85^4), which gives
    // the leading digit in the bits above FRAC_BITS and the remainder as a binary
    // fraction below it. Each later digit is found by multiplying the fraction by
    // 85. The rounding error stays below 2^FRAC_BITS / 85^4 for any 32-bit value,
    // so all five digits come out exact.
    localparam int unsigned FRAC_BITS  = 58;
    localparam int unsigned ACC_BITS   = FRAC_BITS + 7;
    localparam logic [63:0] RADIX_POW4 = 64'd85 * 64'd85 * 64'd85 * 64'd85;
    localparam logic [63:0] RECIP      =
        ((64'd1 << FRAC_BITS) + RADIX_POW4 - 64'd1) / RADIX_POW4;
    localparam logic [31:0] RECIP_LO   = RECIP[31:0];
    localparam logic        RECIP_HI   = RECIP[32];

    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_end;
    } a85_byte_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       group_last;
        logic       message_last;
    } a85_char_t;

endpackage

@@ sv/a85_stream_if.sv @@
interface a85_byte_if;
    logic                 valid;
    logic                 ready;
    a85_pkg::a85_byte_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface a85_char_if;
    logic                 valid;
    logic                 ready;
    a85_pkg::a85_char_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ sv/ascii85_stream_encoder.sv @@
// Channel   Dir  Beat carries                          Accepted when
// msg       in   data_byte[7:0], message_end           msg.valid && msg.ready
// enc       out  out_char[6:0], group_last, message_last enc.valid && enc.ready
//
// Bytes are taken one per cycle while the converter has room; a group of four
// bytes leaves as five characters, one per cycle while enc.ready allows, so the
// sustained rate is set by the single character output register. A zero group
// leaves as one character. Each group passes buffer, multiplier, serializer and output.
// rst_n clears all control state asynchronously; no clearing pass is needed.
// A stall on enc backs up through the converter and then holds msg.ready low.
module ascii85_stream_encoder
(
    input  logic                 clk,
    input  logic                 rst_n,
    a85_byte_if.sink             msg,
    a85_char_if.source           enc
);

    localparam int unsigned AB = a85_pkg::ACC_BITS;
    localparam int unsigned FB = a85_pkg::FRAC_BITS;

    // ------------------------------------------------------------------
    // Group gathering. Bytes are shifted in big-endian; a group is closed
    // when it holds four bytes or the message ends. A closed group waits in
    // the group buffer until the multiplier stage takes it.
    // ------------------------------------------------------------------
    logic [23:0] group_value_reg;
    logic [1:0]  byte_count_reg;
    logic        grp_valid_reg;
    logic [31:0] grp_value_reg;
    logic        grp_end_reg;

    logic        in_ready;
    logic        msg_accept;
    logic        grp_close;
    logic [31:0] gathered;

    // Multiplier stage: the group value times the low word of the scale factor.
    logic        mul_valid_reg;
    logic [63:0] mul_prod_reg;
    logic [31:0] mul_value_reg;
    logic        mul_zero_reg;
    logic        mul_end_reg;

    // Digit serializer: holds the scaled value whose top seven bits are the
    // next digit and whose low bits are the remaining fraction.
    logic          ser_active_reg;
    logic [AB-1:0] ser_acc_reg;
    logic [2:0]    ser_idx_reg;
    logic          ser_zero_reg;
    logic          ser_end_reg;

    // Output register.
    logic               out_valid_reg;
    a85_pkg::a85_char_t out_payload_reg;

    logic          ser_last;
    logic          out_load;
    logic          ser_free;
    logic          ser_load;
    logic          mul_free;
    logic          mul_load;
    logic [AB-1:0] scaled;
    logic [AB-1:0] acc_step;
    logic [6:0]    digit_char;

    // Handshake chain, from the output back to the input.
    assign ser_last   = ser_zero_reg || (ser_idx_reg == a85_pkg::LAST_DIGIT);
    assign out_load   = ser_active_reg && (!out_valid_reg || enc.ready);
    assign ser_free   = !ser_active_reg || (out_load && ser_last);
    assign ser_load   = mul_valid_reg && ser_free;
    assign mul_free   = !mul_valid_reg || ser_load;
    assign mul_load   = grp_valid_reg && mul_free;
    assign in_ready   = !grp_valid_reg || mul_load;
    assign msg_accept = msg.valid && in_ready;

    assign msg.ready  = in_ready;
    assign enc.valid  = out_valid_reg;
    assign enc.payload = out_payload_reg;

    assign gathered  = {group_value_reg, msg.payload.data_byte};
    assign grp_close = (byte_count_reg == a85_pkg::LAST_BYTE) || msg.payload.message_end;

    // Full scaled value: the registered low product plus the value shifted by
    // 32 for the top bit of the scale factor.
    assign scaled = AB'(mul_prod_reg)
                  + (a85_pkg::RECIP_HI ? AB'({mul_value_reg, 32'd0}) : AB'(0));

    // Next digit: remaining fraction times 85.
    assign acc_step   = AB'(ser_acc_reg[FB-1:0]) * AB'(a85_pkg::RADIX);
    assign digit_char = ser_acc_reg[AB-1:FB] + a85_pkg::DIGIT_BASE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= 2'd0;
            group_value_reg <= 24'd0;
            grp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (msg_accept)
            begin
                if (grp_close)
                begin
                    byte_count_reg  <= 2'd0;
                    group_value_reg <= 24'd0;
                end
                else
                begin
                    byte_count_reg  <= byte_count_reg + 2'd1;
                    group_value_reg <= gathered[23:0];
                end
            end
            if (msg_accept && grp_close)
            begin
                grp_valid_reg <= 1'b1;
            end
            else if (mul_load)
            begin
                grp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg_accept && grp_close)
        begin
            grp_value_reg <= gathered;
            grp_end_reg   <= msg.payload.message_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (mul_load)
        begin
            mul_valid_reg <= 1'b1;
        end
        else if (ser_load)
        begin
            mul_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_load)
        begin
            mul_prod_reg  <= 64'(grp_value_reg) * 64'(a85_pkg::RECIP_LO);
            mul_value_reg <= grp_value_reg;
            mul_zero_reg  <= (grp_value_reg == 32'd0);
            mul_end_reg   <= grp_end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_active_reg <= 1'b0;
            ser_idx_reg    <= 3'd0;
        end
        else if (ser_load)
        begin
            ser_active_reg <= 1'b1;
            ser_idx_reg    <= 3'd0;
        end
        else if (out_load)
        begin
            if (ser_last)
            begin
                ser_active_reg <= 1'b0;
            end
            ser_idx_reg <= ser_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_load)
        begin
            ser_acc_reg  <= scaled;
            ser_zero_reg <= mul_zero_reg;
            ser_end_reg  <= mul_end_reg;
        end
        else if (out_load)
        begin
            ser_acc_reg <= acc_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (enc.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_payload_reg.out_char     <= ser_zero_reg ? a85_pkg::ZERO_CHAR : digit_char;
            out_payload_reg.group_last   <= ser_last;
            out_payload_reg.message_last <= ser_last && ser_end_reg;
        end
    end

    // The message end always falls on the close of a group.
    a_msg_last_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        enc.valid |-> (!enc.payload.message_last || enc.payload.group_last))
        else $error("message_last without group_last");

    // The serializer never runs past the fifth digit.
    a_digit_index: assert property (@(posedge clk) disable iff (!rst_n)
        ser_active_reg |-> (ser_idx_reg <= a85_pkg::LAST_DIGIT))
        else $error("digit index out of range");

    // A beat with message_end leaves the gatherer empty for the next message.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_accept && msg.payload.message_end) |=> (byte_count_reg == 2'd0))
        else $error("byte count not cleared at message end");

    // The 'z' code is only ever a whole group on its own.
    a_zero_whole: assert property (@(posedge clk) disable iff (!rst_n)
        (enc.valid && (enc.payload.out_char == a85_pkg::ZERO_CHAR)) |-> enc.payload.group_last)
        else $error("zero character inside a group");

endmodule

@@ dv/ascii85_stream_encoder_tb.sv @@
// Keeps the expected character stream of the encoder. Each byte beat accepted on
// the input side is folded into a running group, and every closed group is turned
// into its expected characters. Output beats are checked in order against them.
class a85_char_scoreboard;

    logic [31:0]          group_acc   = '0;
    logic [1:0]           bytes_held  = '0;
    a85_pkg::a85_char_t   pending_chars[$];
    int                   errors      = 0;
    int                   bytes_seen  = 0;
    int                   chars_seen  = 0;
    int                   zero_groups = 0;
    int                   messages    = 0;

    function void push_char(logic [6:0] ch, logic glast, logic mlast);
        a85_pkg::a85_char_t c;
        c.out_char     = ch;
        c.group_last   = glast;
        c.message_last = mlast;
        pending_chars.push_back(c);
    endfunction

    function void note_byte(a85_pkg::a85_byte_t beat);
        logic [31:0] grp;
        logic [31:0] rest;
        logic [6:0]  digit [a85_pkg::DIGITS];
        int unsigned filled;
        bytes_seen++;
        grp    = {group_acc[23:0], beat.data_byte};
        filled = bytes_held + 1;
        if (filled < 4 && !beat.message_end)
        begin
            group_acc  = grp;
            bytes_held = 2'(filled);
            return;
        end
        group_acc  = '0;
        bytes_held = '0;
        if (beat.message_end)
            messages++;
        if (grp == 32'd0)
        begin
            zero_groups++;
            push_char(a85_pkg::ZERO_CHAR, 1'b1, beat.message_end);
            return;
        end
        rest = grp;
        for (int i = a85_pkg::DIGITS - 1; i >= 0; i--)
        begin
            digit[i] = 7'(rest % a85_pkg::RADIX);
            rest     = rest / a85_pkg::RADIX;
        end
        for (int i = 0; i < a85_pkg::DIGITS; i++)
            push_char(a85_pkg::DIGIT_BASE + digit[i], i == a85_pkg::DIGITS - 1,
                      (i == a85_pkg::DIGITS - 1) && beat.message_end);
    endfunction

    function void check_char(a85_pkg::a85_char_t got);
        a85_pkg::a85_char_t want;
        chars_seen++;
        if (pending_chars.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected character, expected none, actual %0d glast %0b mlast %0b",
                     $time, got.out_char, got.group_last, got.message_last);
            return;
        end
        want = pending_chars.pop_front();
        if (got.out_char !== want.out_char)
        begin
            errors++;
            $display("%0t: out_char expected %0d actual %0d",
                     $time, want.out_char, got.out_char);
        end
        if (got.group_last !== want.group_last)
        begin
            errors++;
            $display("%0t: group_last expected %0b actual %0b",
                     $time, want.group_last, got.group_last);
        end
        if (got.message_last !== want.message_last)
        begin
            errors++;
            $display("%0t: message_last expected %0b actual %0b",
                     $time, want.message_last, got.message_last);
        end
    endfunction

endclass

module ascii85_stream_encoder_tb;

    // Longest run of cycles without any accepted beat before the run is
    // declared hung. The long receiver hold-off is well below this.
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 60;

    // How the bytes of a random message are filled. Zero-heavy fills are there
    // so that the single-character zero group shows up often, also as a
    // partial group at the end of a message.
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_SPARSE} fill_t;

    logic clk;
    logic rst_n;

    a85_byte_if msg_if ();
    a85_char_if enc_if ();

    ascii85_stream_encoder i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .enc   (enc_if)
    );

    a85_char_scoreboard sb;

    // Idle switches for both sides, and a request for one long hold-off that
    // the receiver process counts out on its own.
    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;
    int hold_request = 0;
    int stalled_cycles = 0;

    always #10 clk = ~clk;

    // Monitor. All drivers update on the rising edge with nonblocking
    // assignments, so the values read here are the ones that were stable
    // before the edge, which is exactly when a beat is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (msg_if.valid && msg_if.ready)
                sb.note_byte(msg_if.payload);
            if (enc_if.valid && enc_if.ready)
                sb.check_char(enc_if.payload);
        end
    end

    // Watchdog: only progress on either channel resets the count.
    always @(posedge clk)
    begin
        if ((msg_if.valid && msg_if.ready) || (enc_if.valid && enc_if.ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Drives one byte beat and returns at the edge where it is taken. With no
    // gap drawn, valid simply stays high and the next payload follows on the
    // very next cycle.
    task automatic send_byte(input logic [7:0] data, input logic last);
        a85_pkg::a85_byte_t beat;
        int                 gap;
        beat.data_byte   = data;
        beat.message_end = last;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_if.valid   <= 1'b1;
        msg_if.payload <= beat;
        @(posedge clk);
        while (!msg_if.ready)
            @(posedge clk);
    endtask

    // Sends one whole message; the last byte carries the end flag.
    task automatic send_message(input int len, input fill_t fill);
        logic [7:0] data;
        for (int i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ZERO:   data = 8'h00;
                FILL_SPARSE: data = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                                 : 8'h00;
                default:     data = 8'($urandom_range(0, 255));
            endcase
            send_byte(data, i == len - 1);
        end
    endtask

    // Random message of random length and fill. Lengths are mostly short so
    // that partial groups of one to three bytes come up all the time.
    task automatic send_random_message(output int len);
        int    pick;
        fill_t fill;
        pick = $urandom_range(0, 5);
        fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_SPARSE : FILL_RANDOM;
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 17) : $urandom_range(1, 9);
        send_message(len, fill);
    endtask

    // Waits until every expected character has come out. The first edge lets
    // the monitor fold in the byte taken at the edge the caller returned on.
    task automatic drain_chars();
        @(posedge clk);
        while (sb.pending_chars.size() != 0)
            @(posedge clk);
    endtask

    // Receiver. Before each character it may drop ready for a random number of
    // cycles; a pending long hold-off request takes the place of that gap once.
    initial
    begin
        int gap;
        enc_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                enc_if.ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            else
            begin
                gap = rx_idle ? $urandom_range(0, 6) : 0;
                if (gap > 0)
                begin
                    enc_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            enc_if.ready <= 1'b1;
            @(posedge clk);
            while (!enc_if.valid)
                @(posedge clk);
        end
    end

    // Main sequence.
    initial
    begin
        // Directed opening beats, {data_byte, message_end}: a full zero group
        // that is not the end, the all-ones group closing a message, a lone zero
        // byte at the end, partial groups of one, two and three bytes, a full
        // group in mid-message, and a partial zero group at the end.
        logic [8:0] opening [21] = '{
            {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0},
            {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b1},
            {8'h00, 1'b1},
            {8'h80, 1'b1},
            {8'h01, 1'b0}, {8'hFF, 1'b1},
            {8'h7F, 1'b0}, {8'h00, 1'b0}, {8'hA5, 1'b1},
            {8'h01, 1'b0}, {8'h02, 1'b0}, {8'h03, 1'b0}, {8'h04, 1'b0},
            {8'h00, 1'b0}, {8'h00, 1'b1}
        };
        int random_bytes;
        int len;

        sb = new;
        clk            = 1'b0;
        rst_n          = 1'b0;
        msg_if.valid   = 1'b0;
        msg_if.payload = '0;
        random_bytes   = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with idling on both sides.
        foreach (opening[i])
            send_byte(opening[i][8:1], opening[i][0]);
        random_bytes = $size(opening);

        // Random messages with random gaps on both sides.
        while (random_bytes < 40)
        begin
            send_random_message(len);
            random_bytes += len;
        end

        // A stretch at full rate on both sides.
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        while (random_bytes < 60)
        begin
            send_random_message(len);
            random_bytes += len;
        end

        // Back-pressure: the receiver holds off for a long stretch while the
        // sender keeps offering bytes back to back, so the encoder fills up and
        // has to stall its input.
        rx_idle      = 1'b1;
        hold_request = LONG_HOLD;
        send_message(16, FILL_RANDOM);
        random_bytes += 16;

        // The sender pauses until the output side has caught up completely.
        msg_if.valid <= 1'b0;
        drain_chars();
        tx_idle = 1'b1;

        while (random_bytes < 120)
        begin
            send_random_message(len);
            random_bytes += len;
        end

        // Close out: let the last characters drain, then give the encoder a few
        // more cycles in which nothing further may appear.
        msg_if.valid <= 1'b0;
        drain_chars();
        repeat (10) @(posedge clk);

        if (sb.pending_chars.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected characters never arrived",
                     $time, sb.pending_chars.size());
        end

        $display("Run covered %0d bytes in %0d messages and checked %0d characters.",
                 sb.bytes_seen, sb.messages, sb.chars_seen);
        $display("It saw %0d zero groups, a long output stall and a full output drain.",
                 sb.zero_groups);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
